// ----- hdl/fpw_pkg.sv -----
package fpw_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_FAULT = 2'd2
	} kind_t;

	// input operation codes
	typedef enum logic {
		OP_START = 1'b0,
		OP_ENTRY = 1'b1
	} op_t;

	localparam int FIELD_BITS = 48;
	localparam int FRAME_BITS = 36;
	localparam int ENTRY_BITS = 64;
	localparam int LEFT_BITS  = 31;
	localparam int INDEX_BITS = 9;

	// level of the entry awaited
	localparam logic [1:0] LEVEL_PML4 = 2'd3;
	localparam logic [1:0] LEVEL_PDPT = 2'd2;
	localparam logic [1:0] LEVEL_PD   = 2'd1;
	localparam logic [1:0] LEVEL_PT   = 2'd0;

	// entry bits
	localparam int PRESENT_BIT = 0;
	localparam int LARGE_BIT   = 7;

	// page sizes
	localparam logic [LEFT_BITS-1:0] PAGE_1G = 31'h4000_0000;
	localparam logic [LEFT_BITS-1:0] PAGE_2M = 31'h0020_0000;
	localparam logic [LEFT_BITS-1:0] PAGE_4K = 31'h0000_1000;

	// configuration port
	localparam int APB_DATA_BITS = 64;
	localparam int PADDR_BITS    = 4;
	localparam logic REG_TABLE_WINDOW_BASE = 1'b0;

endpackage

// ----- hdl/fpw_in_if.sv -----
interface fpw_in_if;
	logic                              valid;
	logic                              ready;
	logic                              op;
	logic [fpw_pkg::FRAME_BITS-1:0]    root_frame;
	logic [fpw_pkg::FIELD_BITS-1:0]    virtual_address;
	logic [fpw_pkg::ENTRY_BITS-1:0]    entry;

	modport source (output valid, output op, output root_frame, output virtual_address,
		output entry, input ready);
	modport sink (input valid, input op, input root_frame, input virtual_address,
		input entry, output ready);
endinterface

// ----- hdl/fpw_out_if.sv -----
interface fpw_out_if;
	logic                             valid;
	logic                             ready;
	fpw_pkg::kind_t                   kind;
	logic [fpw_pkg::FIELD_BITS-1:0]   read_address;
	logic [fpw_pkg::FIELD_BITS-1:0]   physical_address;
	logic [fpw_pkg::LEFT_BITS-1:0]    bytes_to_page_end;

	modport source (output valid, output kind, output read_address, output physical_address,
		output bytes_to_page_end, input ready);
	modport sink (input valid, input kind, input read_address, input physical_address,
		input bytes_to_page_end, output ready);
endinterface

// ----- hdl/four_level_page_walker_top.sv -----
// a transaction on item passes through the input register, then the result register,
// before its result is offered on result
// throughput: one transaction per cycle while result is not stalled, set by the single decode
// and 48-bit add between the input register and the result register
// an entry transaction with no walk in progress gives no result
// reset (arst_n low) clears the walk state, window base and both valid flags at once
module four_level_page_walker_top #(
	parameter int ADDRESS_BITS = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	fpw_in_if.sink                                item,
	fpw_out_if.source                             result,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fpw_pkg::PADDR_BITS-1:0]        paddr,
	input  logic [fpw_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [fpw_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                  pready
);

	localparam int FB = fpw_pkg::FIELD_BITS;
	localparam int LB = fpw_pkg::LEFT_BITS;
	localparam int IB = fpw_pkg::INDEX_BITS;

	// wrap mask for entry reads and physical addresses
	localparam logic [FB-1:0] AddrMask = (ADDRESS_BITS >= FB) ? {FB{1'b1}} :
		FB'((64'd1 << ADDRESS_BITS) - 64'd1);

	// 9-bit table index of a virtual address at a given level
	function automatic logic [IB-1:0] level_index(input logic [FB-1:0] va,
		input logic [1:0] lvl);
		logic [IB-1:0] idx;
		case (lvl)
			fpw_pkg::LEVEL_PML4: idx = va[47:39];
			fpw_pkg::LEVEL_PDPT: idx = va[38:30];
			fpw_pkg::LEVEL_PD:   idx = va[29:21];
			default:             idx = va[20:12];
		endcase
		return idx;
	endfunction

	// configuration
	logic [FB-1:0] base_q;

	// walk state
	logic          walking_q;
	logic [1:0]    level_q;
	logic [FB-1:0] held_q;

	// input register
	logic                            valid_s1;
	logic                            op_s1;
	logic [fpw_pkg::FRAME_BITS-1:0]  root_s1;
	logic [FB-1:0]                   va_s1;
	logic [fpw_pkg::ENTRY_BITS-1:0]  entry_s1;

	// result register
	logic                res_valid_q;
	fpw_pkg::kind_t      res_kind_q;
	logic [FB-1:0]       res_rd_q;
	logic [FB-1:0]       res_pa_q;
	logic [LB-1:0]       res_left_q;

	// decode of the staged transaction
	logic                has_result;
	logic                out_free;
	logic                advance;
	logic                load_out;
	logic                cfg_write;
	logic                item_accept;
	fpw_pkg::kind_t      nxt_kind;
	logic [FB-1:0]       nxt_pa;
	logic [LB-1:0]       nxt_left;
	logic [FB-1:0]       tbl_base;
	logic [IB-1:0]       tbl_idx;
	logic [FB-1:0]       rd_sum;
	logic                walking_d;
	logic [1:0]          level_d;
	logic [FB-1:0]       held_d;

	// a start always answers, an entry only during a walk
	assign has_result  = (op_s1 == fpw_pkg::OP_START) || walking_q;
	assign out_free    = !res_valid_q || result.ready;
	assign advance     = valid_s1 && (out_free || !has_result);
	assign load_out    = advance && has_result;
	assign item.ready  = !valid_s1 || advance;
	assign item_accept = item.valid && item.ready;

	// entry read address: window base + table frame + index*8, wrapped
	assign rd_sum = base_q + tbl_base + {{(FB-IB-3){1'b0}}, tbl_idx, 3'b000};

	always_comb begin
		nxt_kind  = fpw_pkg::KIND_READ;
		nxt_pa    = '0;
		nxt_left  = '0;
		tbl_base  = '0;
		tbl_idx   = '0;
		walking_d = walking_q;
		level_d   = level_q;
		held_d    = held_q;
		if (op_s1 == fpw_pkg::OP_START) begin
			// new walk, abandons any walk in progress
			held_d    = va_s1;
			level_d   = fpw_pkg::LEVEL_PML4;
			walking_d = 1'b1;
			tbl_base  = {root_s1, 12'h000};
			tbl_idx   = level_index(va_s1, fpw_pkg::LEVEL_PML4);
		end else if (!entry_s1[fpw_pkg::PRESENT_BIT]) begin
			// not present: fault, all other fields zero
			nxt_kind  = fpw_pkg::KIND_FAULT;
			walking_d = 1'b0;
			level_d   = fpw_pkg::LEVEL_PT;
		end else if (entry_s1[fpw_pkg::LARGE_BIT] && level_q == fpw_pkg::LEVEL_PDPT) begin
			// 1 GB page
			nxt_kind  = fpw_pkg::KIND_DONE;
			nxt_pa    = ({entry_s1[47:30], 30'b0} | {18'b0, held_q[29:0]}) & AddrMask;
			nxt_left  = fpw_pkg::PAGE_1G - {1'b0, held_q[29:0]};
			walking_d = 1'b0;
			level_d   = fpw_pkg::LEVEL_PT;
		end else if (entry_s1[fpw_pkg::LARGE_BIT] && level_q == fpw_pkg::LEVEL_PD) begin
			// 2 MB page
			nxt_kind  = fpw_pkg::KIND_DONE;
			nxt_pa    = ({entry_s1[47:21], 21'b0} | {27'b0, held_q[20:0]}) & AddrMask;
			nxt_left  = fpw_pkg::PAGE_2M - {10'b0, held_q[20:0]};
			walking_d = 1'b0;
			level_d   = fpw_pkg::LEVEL_PT;
		end else if (level_q == fpw_pkg::LEVEL_PT) begin
			// 4 KB page, large bit ignored here
			nxt_kind  = fpw_pkg::KIND_DONE;
			nxt_pa    = ({entry_s1[47:12], 12'b0} | {36'b0, held_q[11:0]}) & AddrMask;
			nxt_left  = fpw_pkg::PAGE_4K - {19'b0, held_q[11:0]};
			walking_d = 1'b0;
		end else begin
			// next level table, large bit at the top level ignored
			level_d  = level_q - 2'd1;
			tbl_base = {entry_s1[47:12], 12'h000};
			tbl_idx  = level_index(held_q, level_q - 2'd1);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			op_s1    <= item.op;
			root_s1  <= item.root_frame;
			va_s1    <= item.virtual_address;
			entry_s1 <= item.entry;
		end
	end

	// walk state moves only when a staged transaction produces its result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q <= 1'b0;
			level_q   <= fpw_pkg::LEVEL_PT;
			held_q    <= '0;
		end else if (load_out) begin
			walking_q <= walking_d;
			level_q   <= level_d;
			held_q    <= held_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_kind_q <= nxt_kind;
			res_rd_q   <= (nxt_kind == fpw_pkg::KIND_READ) ? (rd_sum & AddrMask) : '0;
			res_pa_q   <= nxt_pa;
			res_left_q <= nxt_left;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.kind              = res_kind_q;
	assign result.read_address      = res_rd_q;
	assign result.physical_address  = res_pa_q;
	assign result.bytes_to_page_end = res_left_q;

	// configuration port, register i at byte address 8*i
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
		(paddr[fpw_pkg::PADDR_BITS-1] == fpw_pkg::REG_TABLE_WINDOW_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_write) begin
			base_q <= pwdata[FB-1:0];
		end
	end

	assign prdata = (paddr[fpw_pkg::PADDR_BITS-1] == fpw_pkg::REG_TABLE_WINDOW_BASE) ?
		{{(fpw_pkg::APB_DATA_BITS-FB){1'b0}}, base_q} : '0;

endmodule

// ----- hdl/fpw_checker.sv -----
module fpw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic [1:0]                      kind,
	input logic [fpw_pkg::FIELD_BITS-1:0]  physical_address,
	input logic [fpw_pkg::LEFT_BITS-1:0]   bytes_to_page_end
);

	// stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// only the three defined kinds leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (kind == fpw_pkg::KIND_READ || kind == fpw_pkg::KIND_DONE ||
		kind == fpw_pkg::KIND_FAULT))
		else $error("undefined result kind");

	// requests and faults carry no translation
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != fpw_pkg::KIND_DONE |->
		physical_address == '0 && bytes_to_page_end == '0)
		else $error("translation fields set on non-done result");

	// done translation leaves between one byte and one 1 GB page
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == fpw_pkg::KIND_DONE |->
		bytes_to_page_end != '0 && bytes_to_page_end <= fpw_pkg::PAGE_1G)
		else $error("bytes to page end out of range");

endmodule

bind four_level_page_walker_top fpw_checker u_fpw_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.kind              (result.kind),
	.physical_address  (result.physical_address),
	.bytes_to_page_end (result.bytes_to_page_end)
);

// ----- sim/walk_checker.sv -----
`timescale 1ns / 1ps

module walk_checker
	import fpw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	fpw_in_if                         item,
	fpw_out_if                        result,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_BITS-1:0]     paddr,
	input  logic [APB_DATA_BITS-1:0]  pwdata,
	input  logic                      pready,
	output int unsigned               mismatches,
	output int unsigned               outstanding
);

	typedef struct packed {
		kind_t                 kind;
		logic [FIELD_BITS-1:0] read_address;
		logic [FIELD_BITS-1:0] physical_address;
		logic [LEFT_BITS-1:0]  bytes_left;
	} walk_answer_t;

	localparam logic [PADDR_BITS-1:0] BASE_ADDR = PADDR_BITS'({REG_TABLE_WINDOW_BASE, 3'b000});

	logic [FIELD_BITS-1:0] window_base;
	logic [FIELD_BITS-1:0] walk_va;
	logic                  walk_active;
	logic [1:0]            walk_lvl;
	walk_answer_t          answer_q[$];

	// byte address of the entry for level lvl in the table at table_addr
	function automatic logic [FIELD_BITS-1:0] entry_address(
		input logic [FIELD_BITS-1:0] table_addr,
		input logic [1:0]            lvl
	);
		logic [INDEX_BITS-1:0] idx;
		idx = walk_va[12 + 9 * lvl +: INDEX_BITS];
		return window_base + {table_addr[FIELD_BITS-1:12], 12'h000} + {idx, 3'b000};
	endfunction

	function automatic void walk_step(
		input logic                  op,
		input logic [FRAME_BITS-1:0] frame,
		input logic [FIELD_BITS-1:0] va,
		input logic [ENTRY_BITS-1:0] e
	);
		walk_answer_t a;
		a = '0;
		if (op == OP_START) begin
			walk_va     = va;
			walk_lvl    = LEVEL_PML4;
			walk_active = 1'b1;
			a.kind         = KIND_READ;
			a.read_address = entry_address({frame, 12'h000}, LEVEL_PML4);
			answer_q.push_back(a);
			return;
		end
		// entry with no walk in progress
		if (!walk_active)
			return;
		if (!e[PRESENT_BIT]) begin
			walk_active = 1'b0;
			walk_lvl    = LEVEL_PT;
			a.kind      = KIND_FAULT;
		end else if (walk_lvl == LEVEL_PDPT && e[LARGE_BIT]) begin
			walk_active = 1'b0;
			walk_lvl    = LEVEL_PT;
			a.kind             = KIND_DONE;
			a.physical_address = {e[FIELD_BITS-1:30], walk_va[29:0]};
			a.bytes_left       = PAGE_1G - LEFT_BITS'(walk_va[29:0]);
		end else if (walk_lvl == LEVEL_PD && e[LARGE_BIT]) begin
			walk_active = 1'b0;
			walk_lvl    = LEVEL_PT;
			a.kind             = KIND_DONE;
			a.physical_address = {e[FIELD_BITS-1:21], walk_va[20:0]};
			a.bytes_left       = PAGE_2M - LEFT_BITS'(walk_va[20:0]);
		end else if (walk_lvl == LEVEL_PT) begin
			walk_active = 1'b0;
			a.kind             = KIND_DONE;
			a.physical_address = {e[FIELD_BITS-1:12], walk_va[11:0]};
			a.bytes_left       = PAGE_4K - LEFT_BITS'(walk_va[11:0]);
		end else begin
			walk_lvl       = walk_lvl - 2'd1;
			a.kind         = KIND_READ;
			a.read_address = entry_address(e[FIELD_BITS-1:0], walk_lvl);
		end
		answer_q.push_back(a);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		walk_answer_t want;
		if (!arst_n) begin
			window_base = '0;
			walk_va     = '0;
			walk_active = 1'b0;
			walk_lvl    = LEVEL_PT;
			answer_q.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == BASE_ADDR)
				window_base = pwdata[FIELD_BITS-1:0];
			if (result.valid && result.ready) begin
				if (answer_q.size() == 0) begin
					$error("result transaction with nothing expected");
					mismatches++;
				end else begin
					want = answer_q.pop_front();
					if (result.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result.kind);
						mismatches++;
					end
					if (result.read_address !== want.read_address) begin
						$error("read_address: expected %h, got %h",
							want.read_address, result.read_address);
						mismatches++;
					end
					if (result.physical_address !== want.physical_address) begin
						$error("physical_address: expected %h, got %h",
							want.physical_address, result.physical_address);
						mismatches++;
					end
					if (result.bytes_to_page_end !== want.bytes_left) begin
						$error("bytes_to_page_end: expected %h, got %h",
							want.bytes_left, result.bytes_to_page_end);
						mismatches++;
					end
				end
			end
			if (item.valid && item.ready)
				walk_step(item.op, item.root_frame, item.virtual_address, item.entry);
			outstanding = answer_q.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import fpw_pkg::*;

	// cycles with no transaction anywhere before the run is declared hung
	localparam int WATCHDOG_LIMIT = 3000;
	// long receiver hold-off that backs the walker up into its input
	localparam int HOLD_CYCLES    = 80;
	// walk transactions per idling phase
	localparam int PHASE_ITEMS    = 560;
	// result register latency plus margin, for ignored entries still in flight
	localparam int SETTLE_CYCLES  = 4;

	localparam logic [PADDR_BITS-1:0] BASE_ADDR = PADDR_BITS'({REG_TABLE_WINDOW_BASE, 3'b000});

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [PADDR_BITS-1:0]    paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	// idle percentages of the sender and the receiver, set per phase
	int send_idle;
	int recv_idle;
	// receiver hold-off request, counted down by the receiver itself
	int hold_left;
	// walk transactions sent in the current phase
	int walk_items;

	int unsigned mismatches;
	int unsigned outstanding;

	fpw_in_if  item_ch ();
	fpw_out_if result_ch ();

	four_level_page_walker_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	walk_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one transaction, with random idle cycles ahead of it
	// ready is looked at on the falling edge, where nothing is moving,
	// and the transaction goes through on the rising edge that follows
	task automatic send_item(
		input op_t                   op,
		input logic [FRAME_BITS-1:0] frame,
		input logic [FIELD_BITS-1:0] va,
		input logic [ENTRY_BITS-1:0] e
	);
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid           <= 1'b1;
		item_ch.op              <= op;
		item_ch.root_frame      <= frame;
		item_ch.virtual_address <= va;
		item_ch.entry           <= e;
		do @(negedge clk); while (!item_ch.ready);
		@(posedge clk);
	endtask

	// stop offering and wait until every expected result is back,
	// then give an ignored entry still in the pipe time to drop out
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write of the window base: setup cycle, then access until pready
	// the upper data bits carry junk the register must drop
	task automatic write_window_base(input logic [FIELD_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= BASE_ADDR;
		pwdata  <= {16'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one well-formed walk with random content: a start, then entries until
	// the walk ends; now and then the walk is cut short by the next start,
	// and now and then a stray entry follows once the walk is over
	task automatic run_walk();
		logic [1:0]            lvl;
		logic [ENTRY_BITS-1:0] e;
		bit                    going;
		send_item(OP_START, FRAME_BITS'({$urandom, $urandom}),
			FIELD_BITS'({$urandom, $urandom}), {$urandom, $urandom});
		walk_items++;
		lvl   = LEVEL_PML4;
		going = 1'b1;
		while (going) begin
			if ($urandom_range(99) < 4)
				return;
			e = {$urandom, $urandom};
			e[PRESENT_BIT] = ($urandom_range(99) >= 8);
			e[LARGE_BIT]   = ($urandom_range(99) < 35);
			send_item(OP_ENTRY, FRAME_BITS'({$urandom, $urandom}),
				FIELD_BITS'({$urandom, $urandom}), e);
			walk_items++;
			if (!e[PRESENT_BIT] || lvl == LEVEL_PT
					|| (e[LARGE_BIT] && (lvl == LEVEL_PDPT || lvl == LEVEL_PD)))
				going = 1'b0;
			else
				lvl = lvl - 2'd1;
		end
		if ($urandom_range(99) < 6)
			send_item(OP_ENTRY, FRAME_BITS'({$urandom, $urandom}),
				FIELD_BITS'({$urandom, $urandom}), {$urandom, $urandom});
	endtask

	// receiver: random stalls, or a solid hold-off while one is requested
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// watchdog: any transaction on either channel or the apb port counts as progress
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
					|| (psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		bit held;
		bit paused;
		// everything known from the start, reset held low, then released
		arst_n                  <= 1'b0;
		psel                    <= 1'b0;
		penable                 <= 1'b0;
		pwrite                  <= 1'b0;
		paddr                   <= '0;
		pwdata                  <= '0;
		item_ch.valid           <= 1'b0;
		item_ch.op              <= OP_START;
		item_ch.root_frame      <= '0;
		item_ch.virtual_address <= '0;
		item_ch.entry           <= '0;
		send_idle  = 21;
		recv_idle  = 85;
		hold_left  = 0;
		walk_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-ones window base makes any nonzero table offset wrap the entry address
		write_window_base('1);

		// directed walks
		// entry with no walk in progress gives nothing
		send_item(OP_ENTRY, '1, '1, '1);
		// all-ones root and address; 1 GB page with junk above the frame
		send_item(OP_START, '1, '1, '0);
		send_item(OP_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F);
		send_item(OP_ENTRY, '0, '0, '1);
		// large bit at the top level is ignored; the walk ends on a 2 MB page
		send_item(OP_START, '0, '0, '1);
		send_item(OP_ENTRY, '1, '1, 64'h0000_0000_0000_0081);
		send_item(OP_ENTRY, '1, '1, 64'h0000_0000_0000_0001);
		send_item(OP_ENTRY, '1, '1, '1);
		// full walk; large bit at the last level still means 4 KB, one byte left
		send_item(OP_START, 36'h8_0000_0001, 48'h0000_0000_0FFF, '0);
		send_item(OP_ENTRY, '0, '0, 64'h0000_8000_0000_1001);
		send_item(OP_ENTRY, '0, '0, 64'h0000_7FFF_FFFF_F001);
		send_item(OP_ENTRY, '0, '0, 64'h8000_0000_0000_0001);
		send_item(OP_ENTRY, '0, '0, '1);
		// not present at the top level, every other bit set
		send_item(OP_START, '0, 48'hFFFF_FFFF_F000, '1);
		send_item(OP_ENTRY, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
		// a start in the middle of a walk replaces it; then not present deeper down
		send_item(OP_START, '1, 48'h8000_0000_0000, '0);
		send_item(OP_START, 36'h1_2345_6789, 48'h7FFF_FFFF_FFFF, '0);
		send_item(OP_ENTRY, '0, '0, 64'h0000_0000_0000_0001);
		send_item(OP_ENTRY, '0, '0, 64'h0000_0000_0000_0001);
		send_item(OP_ENTRY, '0, '0, '0);
		// stray entry after the fault
		send_item(OP_ENTRY, '1, '1, '1);
		settle();

		// random walks: slow receiver, then slow sender, then full speed
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 21;
					recv_idle = 85;
					write_window_base('0);
				end
				1: begin
					send_idle = 85;
					recv_idle = 21;
					write_window_base(FIELD_BITS'({$urandom, $urandom}));
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
					write_window_base({1'b1, 47'($urandom)});
				end
			endcase
			walk_items = 0;
			held       = 1'b0;
			paused     = 1'b0;
			while (walk_items < PHASE_ITEMS) begin
				run_walk();
				// mid-phase: receiver holds off while walks keep coming
				if (!held && walk_items >= PHASE_ITEMS / 2) begin
					hold_left = HOLD_CYCLES;
					held      = 1'b1;
				end
				// later on: sender pauses until the walker has drained
				if (!paused && walk_items >= (3 * PHASE_ITEMS) / 4) begin
					settle();
					paused = 1'b1;
				end
			end
			settle();
		end

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
